[sv/blx_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package blx_pkg;

	// Token kinds
	localparam logic [5:0] KindInvalid = 6'd0;
	localparam logic [5:0] KindEos     = 6'd1;
	localparam logic [5:0] KindRem     = 6'd11;
	localparam logic [5:0] KindLe      = 6'd27;
	localparam logic [5:0] KindNe      = 6'd28;
	localparam logic [5:0] KindLt      = 6'd29;
	localparam logic [5:0] KindGe      = 6'd30;
	localparam logic [5:0] KindGl      = 6'd31;
	localparam logic [5:0] KindGt      = 6'd32;
	localparam logic [5:0] KindEq      = 6'd33;
	localparam logic [5:0] KindPlus    = 6'd34;
	localparam logic [5:0] KindMinus   = 6'd35;
	localparam logic [5:0] KindStar    = 6'd36;
	localparam logic [5:0] KindSlash   = 6'd37;
	localparam logic [5:0] KindComma   = 6'd39;
	localparam logic [5:0] KindLparen  = 6'd40;
	localparam logic [5:0] KindRparen  = 6'd41;
	localparam logic [5:0] KindStr     = 6'd42;
	localparam logic [5:0] KindVar     = 6'd43;
	localparam logic [5:0] KindNum     = 6'd44;

	// Keyword table, in match priority order
	localparam int KwCount  = 26;
	localparam int KwMaxLen = 9;
	localparam int KwPosW   = 4;

	localparam logic [8*KwMaxLen-1:0] KwText [KwCount] = '{
		"PRINT", "IF", "THEN", "GOTO", "INPUT", "LET", "GOSUB", "RETURN", "END",
		"REM", "RANDOMIZE", "CLEAR", "LIST", "RUN", "STOP", "RND", "SIN", "COS",
		"TAN", "COT", "ATN", "EXP", "LOG", "ABS", "SQR", "MOD"
	};
	localparam logic [KwPosW-1:0] KwLen [KwCount] = '{
		4'd5, 4'd2, 4'd4, 4'd4, 4'd5, 4'd3, 4'd5, 4'd6, 4'd3,
		4'd3, 4'd9, 4'd5, 4'd4, 4'd3, 4'd4, 4'd3, 4'd3, 4'd3,
		4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3
	};
	localparam logic [5:0] KwKind [KwCount] = '{
		6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7, 6'd8, 6'd9, 6'd10,
		6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17, 6'd18, 6'd19,
		6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd38
	};

	// Result of one keyword match step
	typedef struct packed {
		logic       any;
		logic       exact;
		logic [5:0] kind;
	} kw_res_t;

	// Character of keyword idx at position pos (pos below its length)
	function automatic logic [7:0] kw_char(input int idx, input logic [KwPosW-1:0] pos);
		int sh;
		sh = (int'(KwLen[idx]) - 1 - int'(pos)) * 8;
		if (sh < 0) begin
			return 8'h00;
		end
		return KwText[idx][sh +: 8];
	endfunction

endpackage
`default_nettype wire

[sv/basic_lexer_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Line lexer for BASIC text, one character per input request.
// Input channel: in_valid/in_ready with ch and end_of_line; end_of_line marks the
// end of the line and ch is then ignored. Output channel: out_valid/out_ready
// with kind, length, length_saturated and last; last is set on the final token
// that one input request produces. A request may produce no token at all.
// A request is taken only while the sequencer is idle. Each symbol passes
// through a lookahead buffer read and then one step of the match unit; the
// request is then closed before the sequencer returns to idle, so a new
// character is not taken before the last one is through. A failed keyword
// prefix replays up to seven buffered characters, a failed exponent up to
// two, through the same read and match steps. Tokens are held one deep so
// that last can be marked; a token reaches the output register when the
// next token is found or the request is closed, and the last token of a
// request is visible in the cycle after the closing cycle. The output
// register lets the lexer run on while a token waits; when the receiver stalls
// with both token slots full, the sequencer holds at a new token or the close.
// Reset returns the lexer to a token start with no pending token; the buffer
// contents need no clearing.
module basic_lexer_core #(
	parameter int LOOKAHEAD_DEPTH = 16,
	parameter int MAX_TOKEN_LENGTH = 255
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] ch,
	input  logic       end_of_line,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [5:0] kind,
	output logic [7:0] length,
	output logic       length_saturated,
	output logic       last
);

	localparam int Aw = $clog2(LOOKAHEAD_DEPTH);
	localparam int LenCap = (MAX_TOKEN_LENGTH < 255) ? MAX_TOKEN_LENGTH : 255;
	localparam logic [Aw-1:0] PtrLast = Aw'(LOOKAHEAD_DEPTH - 1);
	localparam int Kc = blx_pkg::KwCount;

	typedef enum logic [3:0] {
		SQ_IDLE  = 4'b0001,
		SQ_READ  = 4'b0010,
		SQ_EXEC  = 4'b0100,
		SQ_FLUSH = 4'b1000
	} seq_t;

	typedef enum logic [10:0] {
		MS_START = 11'b00000000001,
		MS_KW    = 11'b00000000010,
		MS_LT    = 11'b00000000100,
		MS_GT    = 11'b00000001000,
		MS_STR   = 11'b00000010000,
		MS_REM   = 11'b00000100000,
		MS_INT   = 11'b00001000000,
		MS_FRAC  = 11'b00010000000,
		MS_E     = 11'b00100000000,
		MS_ESIGN = 11'b01000000000,
		MS_EXP   = 11'b10000000000
	} ms_t;

	seq_t seq_q;
	ms_t ms_q, ms_d;
	logic [Kc-1:0] mask_q, mask_d, kw_mask;
	logic [blx_pkg::KwPosW-1:0] n_q, n_d, kw_pos;
	logic [7:0] tl_q, tl_d;
	logic over_q, over_d, halted_q, halted_d;
	logic [Aw-1:0] rd_q, cnt_q, ts_q, ts_d, replay_ptr;
	logic [7:0] in_ch_q, rdata, s_ch;
	logic in_eol_q, s_eol, from_buf;
	logic pend_v_q, pend_over_q, out_v_q;
	logic [5:0] pend_kind_q;
	logic [7:0] pend_len_q;
	logic take, keep, emit, replay, step, out_free, out_load, mem_we;
	logic [5:0] e_kind;
	logic [7:0] e_len;
	logic e_over;
	logic [8:0] len_one;
	blx_pkg::kw_res_t kw_res;

	function automatic logic [Aw-1:0] ptr_inc(input logic [Aw-1:0] p);
		return (p == PtrLast) ? '0 : p + 1'b1;
	endfunction

	// Add to the token length, clamping at the cap; returns {over, length}
	function automatic logic [8:0] len_add(input logic [7:0] base, input logic ov,
			input logic [3:0] k);
		logic [8:0] sum;
		sum = {1'b0, base} + {5'b0, k};
		if (sum > 9'(LenCap)) begin
			return {1'b1, 8'(LenCap)};
		end
		return {ov, sum[7:0]};
	endfunction

	// Current symbol: replayed byte or the request itself
	assign from_buf = (rd_q != cnt_q);
	assign s_ch = from_buf ? rdata : in_ch_q;
	assign s_eol = from_buf ? 1'b0 : in_eol_q;

	assign kw_pos = (ms_q == MS_KW) ? n_q : '0;

	blx_kw_match u_kw (
		.mask_in  ((ms_q == MS_KW) ? mask_q : {Kc{1'b1}}),
		.pos      (kw_pos),
		.sym      (s_ch),
		.mask_out (kw_mask),
		.res      (kw_res)
	);

	blx_lbuf #(.DEPTH(LOOKAHEAD_DEPTH), .AW(Aw)) u_lbuf (
		.clk   (clk),
		.we    (mem_we),
		.waddr (rd_q),
		.wdata (s_ch),
		.raddr (rd_q),
		.rdata (rdata)
	);

	// One step of the matcher
	always_comb begin
		logic dig, plus_minus;
		dig = !s_eol && (s_ch inside {["0":"9"]});
		plus_minus = !s_eol && ((s_ch == "+") || (s_ch == "-"));
		ms_d = ms_q;
		mask_d = mask_q;
		n_d = n_q;
		tl_d = tl_q;
		over_d = over_q;
		halted_d = halted_q;
		ts_d = ts_q;
		take = 1'b0;
		keep = 1'b0;
		emit = 1'b0;
		replay = 1'b0;
		replay_ptr = ts_q;
		e_kind = blx_pkg::KindInvalid;
		e_len = 8'd0;
		e_over = 1'b0;
		len_one = len_add(tl_q, over_q, 4'd1);
		case (ms_q)
			MS_KW: begin
				if (!s_eol && kw_res.any) begin
					take = 1'b1;
					if (kw_res.exact) begin
						ms_d = MS_START;
						n_d = '0;
						tl_d = 8'd0;
						over_d = 1'b0;
						if (kw_res.kind == blx_pkg::KindRem) begin
							ms_d = MS_REM;
							tl_d = 8'd3;
						end else begin
							emit = 1'b1;
							e_kind = kw_res.kind;
							e_len = 8'(n_q) + 8'd1;
						end
					end else begin
						keep = 1'b1;
						n_d = n_q + 1'b1;
						mask_d = kw_mask;
					end
				end else begin
					emit = 1'b1;
					e_kind = blx_pkg::KindVar;
					e_len = 8'd1;
					ms_d = MS_START;
					n_d = '0;
					replay = 1'b1;
					replay_ptr = ptr_inc(ts_q);
				end
			end
			MS_LT, MS_GT: begin
				ms_d = MS_START;
				emit = 1'b1;
				if (!s_eol && (s_ch == "=")) begin
					take = 1'b1;
					e_len = 8'd2;
					e_kind = (ms_q == MS_LT) ? blx_pkg::KindLe : blx_pkg::KindGe;
				end else if (!s_eol && (ms_q == MS_LT) && (s_ch == ">")) begin
					take = 1'b1;
					e_len = 8'd2;
					e_kind = blx_pkg::KindNe;
				end else if (!s_eol && (ms_q == MS_GT) && (s_ch == "<")) begin
					take = 1'b1;
					e_len = 8'd2;
					e_kind = blx_pkg::KindGl;
				end else begin
					e_len = 8'd1;
					e_kind = (ms_q == MS_LT) ? blx_pkg::KindLt : blx_pkg::KindGt;
				end
			end
			MS_STR: begin
				if (s_eol) begin
					emit = 1'b1;
					ms_d = MS_START;
					tl_d = 8'd0;
					over_d = 1'b0;
					halted_d = 1'b1;
				end else begin
					take = 1'b1;
					{over_d, tl_d} = len_one;
					if (s_ch == "\"") begin
						emit = 1'b1;
						e_kind = blx_pkg::KindStr;
						{e_over, e_len} = len_one;
						ms_d = MS_START;
						tl_d = 8'd0;
						over_d = 1'b0;
					end
				end
			end
			MS_REM: begin
				if (s_eol) begin
					emit = 1'b1;
					e_kind = blx_pkg::KindRem;
					e_len = tl_q;
					e_over = over_q;
					ms_d = MS_START;
					tl_d = 8'd0;
					over_d = 1'b0;
				end else begin
					take = 1'b1;
					{over_d, tl_d} = len_one;
				end
			end
			MS_INT, MS_FRAC, MS_EXP: begin
				if (dig) begin
					take = 1'b1;
					{over_d, tl_d} = len_one;
				end else if (!s_eol && (ms_q == MS_INT) && (s_ch == ".")) begin
					take = 1'b1;
					{over_d, tl_d} = len_one;
					ms_d = MS_FRAC;
				end else if (!s_eol && (ms_q != MS_EXP) && ((s_ch == "e") || (s_ch == "E"))) begin
					take = 1'b1;
					keep = 1'b1;
					ts_d = rd_q;
					n_d = 4'd1;
					ms_d = MS_E;
				end else begin
					emit = 1'b1;
					e_kind = blx_pkg::KindNum;
					e_len = tl_q;
					e_over = over_q;
					ms_d = MS_START;
					tl_d = 8'd0;
					over_d = 1'b0;
				end
			end
			MS_E, MS_ESIGN: begin
				if (dig) begin
					take = 1'b1;
					{over_d, tl_d} = len_add(tl_q, over_q, n_q + 4'd1);
					n_d = '0;
					ms_d = MS_EXP;
				end else if ((ms_q == MS_E) && plus_minus) begin
					take = 1'b1;
					keep = 1'b1;
					n_d = n_q + 1'b1;
					ms_d = MS_ESIGN;
				end else begin
					emit = 1'b1;
					e_kind = blx_pkg::KindNum;
					e_len = tl_q;
					e_over = over_q;
					ms_d = MS_START;
					n_d = '0;
					tl_d = 8'd0;
					over_d = 1'b0;
					replay = 1'b1;
					replay_ptr = ts_q;
				end
			end
			default: begin
				// Token start
				ms_d = MS_START;
				n_d = '0;
				tl_d = 8'd0;
				over_d = 1'b0;
				take = 1'b1;
				if (halted_q) begin
					if (s_eol) begin
						emit = 1'b1;
						e_kind = blx_pkg::KindEos;
						halted_d = 1'b0;
					end
				end else if (s_eol) begin
					emit = 1'b1;
					e_kind = blx_pkg::KindEos;
				end else if (s_ch inside {" ", "\t", 8'h0C, "\r", "\n"}) begin
					emit = 1'b0;
				end else if (s_ch inside {["A":"Z"]}) begin
					if (kw_res.any) begin
						ms_d = MS_KW;
						n_d = 4'd1;
						mask_d = kw_mask;
						ts_d = rd_q;
						keep = 1'b1;
					end else begin
						emit = 1'b1;
						e_kind = blx_pkg::KindVar;
						e_len = 8'd1;
					end
				end else if (dig) begin
					tl_d = 8'd1;
					ms_d = MS_INT;
				end else begin
					case (s_ch)
						".": begin
							tl_d = 8'd1;
							ms_d = MS_FRAC;
						end
						"\"": begin
							tl_d = 8'd1;
							ms_d = MS_STR;
						end
						"<": ms_d = MS_LT;
						">": ms_d = MS_GT;
						"=": begin emit = 1'b1; e_kind = blx_pkg::KindEq; e_len = 8'd1; end
						"+": begin emit = 1'b1; e_kind = blx_pkg::KindPlus; e_len = 8'd1; end
						"-": begin emit = 1'b1; e_kind = blx_pkg::KindMinus; e_len = 8'd1; end
						"*": begin emit = 1'b1; e_kind = blx_pkg::KindStar; e_len = 8'd1; end
						"/": begin emit = 1'b1; e_kind = blx_pkg::KindSlash; e_len = 8'd1; end
						",": begin emit = 1'b1; e_kind = blx_pkg::KindComma; e_len = 8'd1; end
						"(": begin emit = 1'b1; e_kind = blx_pkg::KindLparen; e_len = 8'd1; end
						")": begin emit = 1'b1; e_kind = blx_pkg::KindRparen; e_len = 8'd1; end
						default: begin
							emit = 1'b1;
							e_kind = blx_pkg::KindInvalid;
							halted_d = 1'b1;
						end
					endcase
				end
			end
		endcase
	end

	// Hold the step while both token slots are full and a new token is found
	assign out_free = !out_v_q || out_ready;
	assign step = (seq_q == SQ_EXEC) && (!emit || !pend_v_q || out_free);
	assign mem_we = step && take && keep && !from_buf;
	assign out_load = (step && emit && pend_v_q)
		|| ((seq_q == SQ_FLUSH) && pend_v_q && out_free);

	// Sequencer and matcher state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= SQ_IDLE;
			ms_q <= MS_START;
			n_q <= '0;
			tl_q <= 8'd0;
			over_q <= 1'b0;
			halted_q <= 1'b0;
			rd_q <= '0;
			cnt_q <= '0;
			ts_q <= '0;
			pend_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
			case (seq_q)
				SQ_IDLE: begin
					if (in_valid) begin
						seq_q <= SQ_READ;
					end
				end
				SQ_READ: seq_q <= SQ_EXEC;
				SQ_EXEC: begin
					if (step) begin
						ms_q <= ms_d;
						n_q <= n_d;
						tl_q <= tl_d;
						over_q <= over_d;
						halted_q <= halted_d;
						ts_q <= ts_d;
						if (emit) begin
							pend_v_q <= 1'b1;
						end
						// Advance, append or rewind the replay pointers
						if (replay) begin
							rd_q <= replay_ptr;
						end else if (take && from_buf) begin
							rd_q <= ptr_inc(rd_q);
						end else if (take && keep) begin
							rd_q <= ptr_inc(rd_q);
							cnt_q <= ptr_inc(rd_q);
						end
						seq_q <= (take && !from_buf) ? SQ_FLUSH : SQ_READ;
					end
				end
				SQ_FLUSH: begin
					if (!pend_v_q) begin
						seq_q <= SQ_IDLE;
					end else if (out_free) begin
						pend_v_q <= 1'b0;
						seq_q <= SQ_IDLE;
					end
				end
				default: seq_q <= SQ_IDLE;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_ch_q <= ch;
			in_eol_q <= end_of_line;
		end
		if (step) begin
			mask_q <= mask_d;
		end
		if (out_load) begin
			kind <= pend_kind_q;
			length <= pend_len_q;
			length_saturated <= pend_over_q;
			last <= (seq_q == SQ_FLUSH);
		end
		if (step && emit) begin
			pend_kind_q <= e_kind;
			pend_len_q <= e_len;
			pend_over_q <= e_over;
		end
	end

	assign in_ready = (seq_q == SQ_IDLE);
	assign out_valid = out_v_q;

	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_q == SQ_IDLE) |-> (!pend_v_q && (rd_q == cnt_q)))
		else $error("idle with pending token or unreplayed bytes");

	a_prefix_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= 4'(blx_pkg::KwMaxLen))
		else $error("buffered prefix too long");

	a_halt_at_start: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |-> (ms_q == MS_START))
		else $error("halted while inside a token");

	a_flush_last: assert property (@(posedge clk) disable iff (!arst_n)
		((seq_q == SQ_FLUSH) && pend_v_q && out_free) |=> (out_v_q && last))
		else $error("closing token not marked last");

endmodule
`default_nettype wire

[sv/blx_kw_match.sv]
`timescale 1ns / 1ps
`default_nettype none
module blx_kw_match (
	input  logic [blx_pkg::KwCount-1:0] mask_in,
	input  logic [blx_pkg::KwPosW-1:0]  pos,
	input  logic [7:0]                  sym,
	output logic [blx_pkg::KwCount-1:0] mask_out,
	output blx_pkg::kw_res_t            res
);

	// Narrow the candidate set by one character; lowest index wins an exact hit
	always_comb begin
		logic [blx_pkg::KwCount-1:0] m;
		m = '0;
		res = '0;
		for (int i = blx_pkg::KwCount - 1; i >= 0; i--) begin
			m[i] = mask_in[i] && (blx_pkg::KwLen[i] > pos) && (blx_pkg::kw_char(i, pos) == sym);
			if (m[i] && (blx_pkg::KwLen[i] == pos + 4'd1)) begin
				res.exact = 1'b1;
				res.kind = blx_pkg::KwKind[i];
			end
		end
		res.any = |m;
		mask_out = m;
	end

endmodule
`default_nettype wire

[sv/blx_lbuf.sv]
`timescale 1ns / 1ps
`default_nettype none
module blx_lbuf #(
	parameter int DEPTH = 16,
	parameter int AW = 4
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem_q [DEPTH];

	// Write one byte, read one byte registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire
